// File: rtl/llae_pkg.sv
// Shared types and constants of the life-like automaton engine.
// Used by every module of the block; depends on nothing.
package llae_pkg;

    localparam int CELL_W  = 5;
    localparam int CNT_W   = 4;
    localparam int TALLY_W = 13;

    localparam logic [CELL_W-1:0] ALIVE_BIT  = 5'h01;
    localparam logic [CELL_W-1:0] COUNT_UNIT = 5'h02;

    localparam logic [1:0] ACT_TOGGLE = 2'd0;
    localparam logic [1:0] ACT_EVOLVE = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    localparam logic [1:0] CFG_SURVIVE_LOW  = 2'd0;
    localparam logic [1:0] CFG_SURVIVE_HIGH = 2'd1;
    localparam logic [1:0] CFG_BIRTH_COUNT  = 2'd2;

    typedef enum logic [1:0] {
        OFS_MINUS = 2'd0,
        OFS_ZERO  = 2'd1,
        OFS_PLUS  = 2'd2
    } t_ofs;

    typedef struct packed {
        t_ofs dr;
        t_ofs dc;
    } t_step_ofs;

    // Step 0 is the cell itself, steps 1 to 8 are its eight neighbors.
    function automatic t_step_ofs step_ofs(input logic [3:0] step);
        t_step_ofs o;
        case (step)
            4'd1:    o = '{OFS_MINUS, OFS_MINUS};
            4'd2:    o = '{OFS_MINUS, OFS_ZERO};
            4'd3:    o = '{OFS_MINUS, OFS_PLUS};
            4'd4:    o = '{OFS_ZERO,  OFS_MINUS};
            4'd5:    o = '{OFS_ZERO,  OFS_PLUS};
            4'd6:    o = '{OFS_PLUS,  OFS_MINUS};
            4'd7:    o = '{OFS_PLUS,  OFS_ZERO};
            4'd8:    o = '{OFS_PLUS,  OFS_PLUS};
            default: o = '{OFS_ZERO,  OFS_ZERO};
        endcase
        return o;
    endfunction

endpackage

// File: rtl/life_like_automaton_engine_core.sv
// Top level of the life-like automaton engine: cell and snapshot memories and sequencer.
// Depends on llae_pkg and llae_nbr_addr.
//
// Usage: an item is taken at a clock edge with start high and busy low. It carries an
// action (toggle, evolve, read) and a flat cell index. Exactly one result follows, shown
// for one cycle with o_done high; the receiver cannot stall it.
// A toggle splits the index into row and column, then runs nine read-modify-write steps
// on the cell memory. An evolve copies the cell memory into the snapshot memory in one
// pass, reads each snapshot entry in a second pass, and runs the nine-step update for
// every cell that changes.
// An item other than an evolve with an index off the grid answers zeros in the next cycle.
// After reset a clearing pass zeroes the cell memory; busy is high meanwhile. Rule
// registers are written through the cfg channel, which is always ready.
module life_like_automaton_engine_core #(
    parameter int GRID_SIDE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [11:0] i_cell_index,
    output logic        o_done,
    output logic        o_cell_alive,
    output logic [3:0]  o_neighbour_total,
    output logic [12:0] o_births,
    output logic [12:0] o_deaths,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(GRID_SIDE);
    localparam int DW    = llae_pkg::CELL_W;
    localparam int NW    = llae_pkg::CNT_W;
    localparam int TW    = llae_pkg::TALLY_W;
    localparam int QS    = AW + CW;
    localparam int MW    = AW + 1;
    localparam int PW    = AW + MW;
    localparam logic [AW-1:0] ADDR_LAST = AW'(CELLS - 1);
    localparam logic [CW-1:0] SIDE_LAST = CW'(GRID_SIDE - 1);
    localparam logic [MW-1:0] DIV_MUL   = MW'((2 ** QS + GRID_SIDE - 1) / GRID_SIDE);

    typedef enum logic [10:0] {
        S_CLEAR   = 11'b000_0000_0001,
        S_IDLE    = 11'b000_0000_0010,
        S_DIV     = 11'b000_0000_0100,
        S_COPY    = 11'b000_0000_1000,
        S_SCAN_RD = 11'b000_0001_0000,
        S_SCAN_EV = 11'b000_0010_0000,
        S_FLIP_RD = 11'b000_0100_0000,
        S_FLIP_WR = 11'b000_1000_0000,
        S_OUT_RD  = 11'b001_0000_0000,
        S_OUT     = 11'b010_0000_0000,
        S_SPARE   = 11'b100_0000_0000
    } t_state;

    logic [DW-1:0] cell_mem [CELLS];
    logic [DW-1:0] snap_mem [CELLS];

    t_state        r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [3:0]    r_step, n_step;
    logic          r_evolve, n_evolve;
    logic          r_was_alive, n_was_alive;
    logic [TW-1:0] r_births, n_births;
    logic [TW-1:0] r_deaths, n_deaths;
    logic          r_copy_vld, n_copy_vld;
    logic [AW-1:0] r_copy_wa, n_copy_wa;
    logic [NW-1:0] r_surv_lo, r_surv_hi, r_birth;
    logic          r_done, n_done;
    logic          r_alive, n_alive;
    logic [NW-1:0] r_total, n_total;
    logic [TW-1:0] r_out_births, n_out_births;
    logic [TW-1:0] r_out_deaths, n_out_deaths;
    logic [DW-1:0] r_cell_rd;
    logic [DW-1:0] r_snap_rd;

    logic          cell_we;
    logic [AW-1:0] cell_ra, cell_wa;
    logic [DW-1:0] cell_wd;
    logic [AW-1:0] snap_ra;
    logic [AW-1:0] nbr_addr;
    logic          advance;
    logic          flip;
    logic [NW-1:0] cnt_new;
    logic [NW-1:0] snap_cnt;
    logic [PW-1:0] row_prod;

    llae_nbr_addr #(
        .GRID_SIDE (GRID_SIDE),
        .CW        (CW),
        .AW        (AW)
    ) u_nbr (
        .i_row  (r_row),
        .i_col  (r_col),
        .i_step (r_step),
        .o_addr (nbr_addr)
    );

    assign row_prod = PW'(i_cell_index) * PW'(DIV_MUL);

    always_ff @(posedge i_clk) begin
        if (cell_we) begin
            cell_mem[cell_wa] <= cell_wd;
        end
        r_cell_rd <= cell_mem[cell_ra];
    end

    always_ff @(posedge i_clk) begin
        if (r_copy_vld) begin
            snap_mem[r_copy_wa] <= r_cell_rd;
        end
        r_snap_rd <= snap_mem[snap_ra];
    end

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_idx        = r_idx;
        n_row        = r_row;
        n_col        = r_col;
        n_step       = r_step;
        n_evolve     = r_evolve;
        n_was_alive  = r_was_alive;
        n_births     = r_births;
        n_deaths     = r_deaths;
        n_copy_vld   = 1'b0;
        n_copy_wa    = r_copy_wa;
        n_done       = 1'b0;
        n_alive      = r_alive;
        n_total      = r_total;
        n_out_births = r_out_births;
        n_out_deaths = r_out_deaths;
        cell_we      = 1'b0;
        cell_ra      = r_addr;
        cell_wa      = r_addr;
        cell_wd      = '0;
        snap_ra      = r_addr;
        advance      = 1'b0;
        snap_cnt     = r_snap_rd[DW-1:1];
        flip         = 1'b0;
        cnt_new      = r_was_alive ? r_cell_rd[DW-1:1] - NW'(1) : r_cell_rd[DW-1:1] + NW'(1);

        case (r_state)
            S_CLEAR: begin
                cell_we = 1'b1;
                if (r_addr == ADDR_LAST) begin
                    n_state = S_IDLE;
                    n_addr  = '0;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_idx = AW'(i_cell_index);
                    if (i_action == llae_pkg::ACT_EVOLVE) begin
                        n_state  = S_COPY;
                        n_addr   = '0;
                        n_births = '0;
                        n_deaths = '0;
                    end else if ({20'd0, i_cell_index} >= 32'(CELLS)) begin
                        n_done       = 1'b1;
                        n_alive      = 1'b0;
                        n_total      = '0;
                        n_out_births = '0;
                        n_out_deaths = '0;
                    end else if (i_action == llae_pkg::ACT_TOGGLE) begin
                        n_state = S_DIV;
                        n_row   = CW'(row_prod >> QS);
                    end else begin
                        n_state = S_OUT_RD;
                    end
                end
            end
            S_DIV: begin
                n_col    = CW'(r_idx - AW'(AW'(r_row) * AW'(GRID_SIDE)));
                n_step   = '0;
                n_evolve = 1'b0;
                n_state  = S_FLIP_RD;
            end
            S_COPY: begin
                n_copy_vld = 1'b1;
                n_copy_wa  = r_addr;
                if (r_addr == ADDR_LAST) begin
                    n_addr  = '0;
                    n_row   = '0;
                    n_col   = '0;
                    n_state = S_SCAN_RD;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                if (r_snap_rd != '0) begin
                    if (r_snap_rd[0]) begin
                        flip = (snap_cnt < r_surv_lo) || (snap_cnt > r_surv_hi);
                    end else begin
                        flip = (snap_cnt == r_birth);
                    end
                end
                if (flip) begin
                    if (r_snap_rd[0]) begin
                        n_deaths = (r_deaths == '1) ? r_deaths : r_deaths + TW'(1);
                    end else begin
                        n_births = (r_births == '1) ? r_births : r_births + TW'(1);
                    end
                    n_step   = '0;
                    n_evolve = 1'b1;
                    n_state  = S_FLIP_RD;
                end else begin
                    advance = 1'b1;
                end
            end
            S_FLIP_RD: begin
                cell_ra = nbr_addr;
                n_state = S_FLIP_WR;
            end
            S_FLIP_WR: begin
                cell_we = 1'b1;
                cell_wa = nbr_addr;
                if (r_step == '0) begin
                    cell_wd     = r_cell_rd ^ llae_pkg::ALIVE_BIT;
                    n_was_alive = r_cell_rd[0];
                end else begin
                    cell_wd = {cnt_new, r_cell_rd[0]};
                end
                if (r_step == 4'd8) begin
                    if (r_evolve) begin
                        advance = 1'b1;
                    end else begin
                        n_state = S_OUT_RD;
                    end
                end else begin
                    n_step  = r_step + 4'd1;
                    n_state = S_FLIP_RD;
                end
            end
            S_OUT_RD: begin
                cell_ra = r_idx;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_done       = 1'b1;
                n_alive      = r_cell_rd[0];
                n_total      = r_cell_rd[DW-1:1];
                n_out_births = '0;
                n_out_deaths = '0;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (advance) begin
            if (r_addr == ADDR_LAST) begin
                n_done       = 1'b1;
                n_alive      = 1'b0;
                n_total      = '0;
                n_out_births = n_births;
                n_out_deaths = n_deaths;
                n_state      = S_IDLE;
            end else begin
                n_addr  = r_addr + AW'(1);
                n_state = S_SCAN_RD;
                if (r_col == SIDE_LAST) begin
                    n_col = '0;
                    n_row = r_row + CW'(1);
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_addr     <= '0;
            r_copy_vld <= 1'b0;
            r_done     <= 1'b0;
            r_surv_lo  <= NW'(2);
            r_surv_hi  <= NW'(3);
            r_birth    <= NW'(3);
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_copy_vld <= n_copy_vld;
            r_done     <= n_done;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    llae_pkg::CFG_SURVIVE_LOW:  r_surv_lo <= i_cfg_data;
                    llae_pkg::CFG_SURVIVE_HIGH: r_surv_hi <= i_cfg_data;
                    llae_pkg::CFG_BIRTH_COUNT:  r_birth   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_row        <= n_row;
        r_col        <= n_col;
        r_step       <= n_step;
        r_evolve     <= n_evolve;
        r_was_alive  <= n_was_alive;
        r_births     <= n_births;
        r_deaths     <= n_deaths;
        r_copy_wa    <= n_copy_wa;
        r_alive      <= n_alive;
        r_total      <= n_total;
        r_out_births <= n_out_births;
        r_out_deaths <= n_out_deaths;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_done            = r_done;
    assign o_cell_alive      = r_alive;
    assign o_neighbour_total = r_total;
    assign o_births          = r_out_births;
    assign o_deaths          = r_out_deaths;

endmodule

// File: rtl/llae_nbr_addr.sv
// Wrapped neighbor address generator of the life-like automaton engine.
// Depends on llae_pkg.
module llae_nbr_addr #(
    parameter int GRID_SIDE = 64,
    parameter int CW        = $clog2(GRID_SIDE),
    parameter int AW        = $clog2(GRID_SIDE * GRID_SIDE)
) (
    input  logic [CW-1:0] i_row,
    input  logic [CW-1:0] i_col,
    input  logic [3:0]    i_step,
    output logic [AW-1:0] o_addr
);

    localparam logic [CW-1:0] SIDE_LAST = CW'(GRID_SIDE - 1);

    llae_pkg::t_step_ofs ofs;
    logic [CW-1:0] row_sel;
    logic [CW-1:0] col_sel;

    always_comb begin
        ofs = llae_pkg::step_ofs(i_step);
        case (ofs.dr)
            llae_pkg::OFS_MINUS: row_sel = (i_row == '0) ? SIDE_LAST : i_row - CW'(1);
            llae_pkg::OFS_PLUS:  row_sel = (i_row == SIDE_LAST) ? '0 : i_row + CW'(1);
            default:             row_sel = i_row;
        endcase
        case (ofs.dc)
            llae_pkg::OFS_MINUS: col_sel = (i_col == '0) ? SIDE_LAST : i_col - CW'(1);
            llae_pkg::OFS_PLUS:  col_sel = (i_col == SIDE_LAST) ? '0 : i_col + CW'(1);
            default:             col_sel = i_col;
        endcase
        o_addr = AW'(AW'(row_sel) * AW'(GRID_SIDE)) + AW'(col_sel);
    end

endmodule

// File: rtl/llae_checker.sv
// Port-level checks of the life-like automaton engine and their binding to the top level.
// Depends on llae_pkg and life_like_automaton_engine_core.
module llae_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_action,
    input logic        o_done,
    input logic        o_cell_alive,
    input logic [3:0]  o_neighbour_total,
    input logic [12:0] o_births,
    input logic [12:0] o_deaths
);

    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy) || $past(start))
        else $error("result without a pending item");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_births == '0 && o_deaths == '0) ||
                   (!o_cell_alive && o_neighbour_total == '0))
        else $error("cell fields and generation tallies both nonzero");

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_neighbour_total <= 4'd8)
        else $error("neighbor count above eight");

    a_evolve_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == llae_pkg::ACT_EVOLVE) |=> busy && !o_done)
        else $error("evolve did not start a pass");

endmodule

bind life_like_automaton_engine_core llae_checker u_llae_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .i_action          (i_action),
    .o_done            (o_done),
    .o_cell_alive      (o_cell_alive),
    .o_neighbour_total (o_neighbour_total),
    .o_births          (o_births),
    .o_deaths          (o_deaths)
);

// File: dv/life_like_automaton_engine_core_tb.sv
// Self-checking testbench of life_like_automaton_engine_core: toggles, reads and evolves
// on the 64x64 torus, checked against a cycle-free model of the grid and the rule set.
// Depends on llae_pkg and the engine RTL only.
module life_like_automaton_engine_core_tb;

    localparam int SIDE = 64;
    localparam int CELLS = SIDE * SIDE;
    localparam int CYCLE_LIMIT = 5000000;
    localparam int SETTLE_CYCLES = 64;
    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam logic [12:0] TALLY_MAX = 13'd8191;

    typedef struct {
        logic        alive;
        logic [3:0]  total;
        logic [12:0] births;
        logic [12:0] deaths;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_action;
    logic [11:0] i_cell_index;
    logic        o_done;
    logic        o_cell_alive;
    logic [3:0]  o_neighbour_total;
    logic [12:0] o_births;
    logic [12:0] o_deaths;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [3:0]  i_cfg_data;

    logic [4:0] world [CELLS];
    logic [4:0] frozen [CELLS];
    logic [3:0] rule_survive_low;
    logic [3:0] rule_survive_high;
    logic [3:0] rule_birth;
    t_answer    pending_answers [$];
    int         fail_count = 0;
    int         item_count;
    int         evolve_count;
    int         born_total;
    int         died_total;
    int         cycle_count = 0;
    bit         gaps_on;

    life_like_automaton_engine_core #(.GRID_SIDE(SIDE)) uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("life_like_automaton_engine_core_tb failed");
            $finish;
        end
    end

    // Outputs only move at rising edges, so the falling edge sees them settled.
    always @(negedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_done) begin
            if (pending_answers.size() == 0) begin
                $error("result with no item outstanding");
                fail_count++;
            end else begin
                want = pending_answers.pop_front();
                if (o_cell_alive !== want.alive) begin
                    $error("cell_alive expected %0d actual %0d", want.alive, o_cell_alive);
                    fail_count++;
                end
                if (o_neighbour_total !== want.total) begin
                    $error("neighbour_total expected %0d actual %0d",
                           want.total, o_neighbour_total);
                    fail_count++;
                end
                if (o_births !== want.births) begin
                    $error("births expected %0d actual %0d", want.births, o_births);
                    fail_count++;
                end
                if (o_deaths !== want.deaths) begin
                    $error("deaths expected %0d actual %0d", want.deaths, o_deaths);
                    fail_count++;
                end
            end
        end
    end

    function automatic void flip_world_cell(int idx);
        int row, col, n;
        logic was_alive;
        logic [3:0] cnt;
        row = idx / SIDE;
        col = idx % SIDE;
        was_alive = world[idx][0];
        world[idx][0] = ~was_alive;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                if (dr != 0 || dc != 0) begin
                    n = ((row + SIDE + dr) % SIDE) * SIDE + (col + SIDE + dc) % SIDE;
                    cnt = world[n][4:1];
                    cnt = was_alive ? cnt - 4'd1 : cnt + 4'd1;
                    world[n][4:1] = cnt;
                end
            end
        end
    endfunction

    function automatic t_answer apply_action(logic [1:0] act, logic [11:0] idx);
        t_answer a;
        logic [3:0] cnt;
        a = '{1'b0, 4'd0, 13'd0, 13'd0};
        if (act == llae_pkg::ACT_EVOLVE) begin
            frozen = world;
            for (int i = 0; i < CELLS; i++) begin
                cnt = frozen[i][4:1];
                if (frozen[i] != 5'd0) begin
                    if (frozen[i][0]) begin
                        if (cnt < rule_survive_low || cnt > rule_survive_high) begin
                            flip_world_cell(i);
                            if (a.deaths < TALLY_MAX) a.deaths++;
                        end
                    end else if (cnt == rule_birth) begin
                        flip_world_cell(i);
                        if (a.births < TALLY_MAX) a.births++;
                    end
                end
            end
            evolve_count++;
            born_total += a.births;
            died_total += a.deaths;
        end else if (int'(idx) < CELLS) begin
            if (act == llae_pkg::ACT_TOGGLE) flip_world_cell(idx);
            a.alive = world[idx][0];
            a.total = world[idx][4:1];
        end
        return a;
    endfunction

    task automatic send_item(logic [1:0] act, logic [11:0] idx);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_action <= act;
        i_cell_index <= idx;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        pending_answers.push_back(apply_action(act, idx));
        item_count++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_rule(logic [1:0] reg_index, logic [3:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= reg_index;
        i_cfg_data <= value;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        case (reg_index)
            llae_pkg::CFG_SURVIVE_LOW:  rule_survive_low = value;
            llae_pkg::CFG_SURVIVE_HIGH: rule_survive_high = value;
            llae_pkg::CFG_BIRTH_COUNT:  rule_birth = value;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_rules(logic [3:0] lo, logic [3:0] hi, logic [3:0] birth);
        drain_results();
        write_rule(llae_pkg::CFG_SURVIVE_LOW, lo);
        write_rule(llae_pkg::CFG_SURVIVE_HIGH, hi);
        write_rule(llae_pkg::CFG_BIRTH_COUNT, birth);
    endtask

    task automatic test_empty_world();
        send_item(llae_pkg::ACT_READ, 12'd0);
        send_item(llae_pkg::ACT_READ, 12'd4095);
        send_item(llae_pkg::ACT_EVOLVE, 12'd1234);
    endtask

    // A corner cell must count neighbors across both wrapped edges.
    task automatic test_corner_wrap();
        send_item(llae_pkg::ACT_TOGGLE, 12'd0);
        send_item(llae_pkg::ACT_READ, 12'd4095);
        send_item(llae_pkg::ACT_READ, 12'd63);
        send_item(llae_pkg::ACT_READ, 12'd4032);
        send_item(ACT_SPARE, 12'd65);
        send_item(llae_pkg::ACT_TOGGLE, 12'd4095);
        send_item(llae_pkg::ACT_READ, 12'd0);
        send_item(llae_pkg::ACT_EVOLVE, 12'd0);
        send_item(llae_pkg::ACT_READ, 12'd0);
    endtask

    // A blinker laid across the left and right edges flips between phases.
    task automatic test_wrapped_blinker();
        send_item(llae_pkg::ACT_TOGGLE, 12'd63);
        send_item(llae_pkg::ACT_TOGGLE, 12'd0);
        send_item(llae_pkg::ACT_TOGGLE, 12'd1);
        send_item(llae_pkg::ACT_EVOLVE, 12'd0);
        send_item(llae_pkg::ACT_READ, 12'd4032);
        send_item(llae_pkg::ACT_READ, 12'd64);
        send_item(llae_pkg::ACT_EVOLVE, 12'hFFF);
        send_item(ACT_SPARE, 12'd0);
    endtask

    task automatic test_random_soup(int n_items);
        int cr, cc, pick;
        logic [11:0] idx;
        cr = $urandom_range(0, SIDE - 1);
        cc = $urandom_range(0, SIDE - 1);
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(0, 99);
            idx = 12'(((cr + $urandom_range(0, 4)) % SIDE) * SIDE
                      + (cc + $urandom_range(0, 4)) % SIDE);
            if (pick < 50) send_item(llae_pkg::ACT_TOGGLE, idx);
            else if (pick < 70) send_item(llae_pkg::ACT_READ, idx);
            else if (pick < 75) send_item(ACT_SPARE, idx);
            else if (pick < 88) send_item(llae_pkg::ACT_EVOLVE, 12'($urandom));
            else if (pick < 94) send_item(llae_pkg::ACT_TOGGLE, 12'($urandom));
            else send_item(llae_pkg::ACT_READ, 12'($urandom));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_action = llae_pkg::ACT_READ;
        i_cell_index = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = llae_pkg::CFG_SURVIVE_LOW;
        i_cfg_data = '0;
        item_count = 0;
        evolve_count = 0;
        born_total = 0;
        died_total = 0;
        gaps_on = 1'b1;
        rule_survive_low = 4'd2;
        rule_survive_high = 4'd3;
        rule_birth = 4'd3;
        for (int i = 0; i < CELLS; i++) world[i] = 5'd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);

        test_empty_world();
        test_corner_wrap();
        test_wrapped_blinker();
        test_random_soup(20);
        set_rules(4'd0, 4'd8, 4'd0);
        test_random_soup(15);
        set_rules(4'd8, 4'd0, 4'd8);
        test_random_soup(15);
        set_rules(4'd15, 4'd15, 4'd15);
        test_random_soup(10);
        set_rules(4'd1, 4'd4, 4'd2);
        test_random_soup(15);
        set_rules(4'd2, 4'd3, 4'd3);
        gaps_on = 1'b0;
        test_random_soup(25);
        drain_results();

        $display("Sent %0d items with %0d generations (%0d births, %0d deaths) over five rules.",
                 item_count, evolve_count, born_total, died_total);
        if (fail_count == 0) begin
            $display("life_like_automaton_engine_core_tb passed");
        end else begin
            $display("life_like_automaton_engine_core_tb failed");
        end
        $finish;
    end

endmodule
